// ===== design/cwc_pkg.sv =====
package cwc_pkg;

  localparam int unsigned ACK_W      = 32;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned DUP_W      = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [DUP_W-1:0]      DUP_LIMIT_DEF   = 2'd3;
  localparam logic [WIN_W-1:0]      ONE_SEGMENT     = 32'h0001_0000;
  localparam logic [THR_W-2:0]      MIN_THRESHOLD   = 15'd2;
  localparam logic [THR_W-1:0]      THRESHOLD_RESET = 16'd64;
  localparam logic [CFG_ADDR_W-1:0] ADDR_INIT_THR   = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                               input logic [WIN_W-1:0] b);
    logic [WIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIN_W] ? {WIN_W{1'b1}} : s[WIN_W-1:0];
  endfunction

endpackage

// ===== design/cwc_div.sv =====
// Serial restoring divider: quotient = floor(2^32 / divisor), low 32 bits.
// One quotient bit per cycle; done pulses as the last quotient bit is registered.
module cwc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cwc_pkg::WIN_W-1:0]        divisor,
  output logic                             done,
  output logic [cwc_pkg::WIN_W-1:0]        quotient
);

  localparam int unsigned W = cwc_pkg::WIN_W;

  logic         busy;
  logic [5:0]   count;
  logic [W:0]   rem;
  logic [W:0]   trial;
  logic         fits;

  // dividend is 2^W: a one at the first step, zeros after
  assign trial = {rem[W-1:0], (count == 6'(W))};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(W);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? (trial - {1'b0, divisor}) : trial;
      quotient <= {quotient[W-2:0], fits};
    end
  end

endmodule

// ===== design/congestion_window_controller_top.sv =====
// The accepted word is registered on the move to S_CALC. In slow start or on a
// duplicate ack S_CALC goes on to S_DONE; in congestion avoidance it passes through
// S_DIV, which waits for the serial divider. S_DONE registers the result word.
// One word at a time: s_tready is low from acceptance until the result is
// registered; a result waiting on m_tready holds the next word back at that point.
// Reset (rst, synchronous): one-segment window, threshold 64, slow start, no ack.
module congestion_window_controller_top #(
  parameter logic [cwc_pkg::DUP_W-1:0] DUP_LIMIT = cwc_pkg::DUP_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cwc_pkg::ACK_W-1:0]           s_tdata,  // [31:0] ack_number
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] window, [47:32] threshold, [48] slow-start flag,
  // [49] fast_retransmit, [51:50] duplicate_count, [55:52] zero
  output logic [cwc_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cwc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [cwc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned WIN_W = cwc_pkg::WIN_W;
  localparam int unsigned THR_W = cwc_pkg::THR_W;
  localparam int unsigned DUP_W = cwc_pkg::DUP_W;

  cwc_pkg::state_t          state;
  logic                     div_start;
  logic                     div_done;

  logic [THR_W-1:0]         initial_threshold;
  logic [WIN_W-1:0]         window_reg;
  logic [THR_W-1:0]         threshold_reg;
  logic                     slow_start_flag;
  logic [cwc_pkg::ACK_W-1:0] previous_ack;
  logic                     previous_ack_valid;
  logic [DUP_W-1:0]         dup_counter;
  logic [cwc_pkg::ACK_W-1:0] ack;
  logic                     fired;
  logic [WIN_W-1:0]         quotient;

  logic                     cfg_wr;
  logic                     is_dup;
  logic [DUP_W-1:0]         dup_inc;
  logic [THR_W-2:0]         half;
  logic [WIN_W-1:0]         ss_window;
  logic [WIN_W-1:0]         ca_inc;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == cwc_pkg::ADDR_INIT_THR);
  assign prdata   = (paddr == cwc_pkg::ADDR_INIT_THR) ?
                    {{(cwc_pkg::CFG_DATA_W-THR_W){1'b0}}, initial_threshold} : '0;

  assign s_tready = (state == cwc_pkg::S_IDLE);

  assign is_dup    = previous_ack_valid && (ack == previous_ack);
  assign dup_inc   = dup_counter + {{(DUP_W-1){1'b0}}, 1'b1};
  assign half      = (window_reg[WIN_W-1:17] < cwc_pkg::MIN_THRESHOLD) ?
                     cwc_pkg::MIN_THRESHOLD : window_reg[WIN_W-1:17];
  assign ss_window = cwc_pkg::sat_add(window_reg, cwc_pkg::ONE_SEGMENT);
  // zero window cannot arise; guarded anyway
  assign ca_inc    = (window_reg == '0) ? '0 : quotient;

  assign div_start = (state == cwc_pkg::S_CALC) && !is_dup && !slow_start_flag;

  cwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window_reg),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) ack <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= cwc_pkg::S_IDLE;
      initial_threshold  <= cwc_pkg::THRESHOLD_RESET;
      window_reg         <= cwc_pkg::ONE_SEGMENT;
      threshold_reg      <= cwc_pkg::THRESHOLD_RESET;
      slow_start_flag    <= 1'b1;
      previous_ack       <= '0;
      previous_ack_valid <= 1'b0;
      dup_counter        <= '0;
      fired              <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_wr) begin
        initial_threshold <= pwdata[THR_W-1:0];
        threshold_reg     <= pwdata[THR_W-1:0];
      end
      if (m_tvalid && m_tready && (state != cwc_pkg::S_DONE)) m_tvalid <= 1'b0;

      case (state)
        cwc_pkg::S_IDLE: begin
          if (s_tvalid) state <= cwc_pkg::S_CALC;
        end
        cwc_pkg::S_CALC: begin
          fired <= is_dup && (dup_inc == DUP_LIMIT);
          if (is_dup) begin
            if (dup_inc == DUP_LIMIT) begin
              threshold_reg   <= {1'b0, half};
              window_reg      <= cwc_pkg::ONE_SEGMENT;
              slow_start_flag <= 1'b1;
              dup_counter     <= '0;
            end else begin
              dup_counter <= dup_inc;
            end
            state <= cwc_pkg::S_DONE;
          end else begin
            dup_counter        <= '0;
            previous_ack       <= ack;
            previous_ack_valid <= 1'b1;
            if (slow_start_flag) begin
              window_reg <= ss_window;
              if (ss_window >= {threshold_reg, 16'h0000}) slow_start_flag <= 1'b0;
              state <= cwc_pkg::S_DONE;
            end else begin
              state <= cwc_pkg::S_DIV;
            end
          end
        end
        cwc_pkg::S_DIV: begin
          if (div_done) begin
            window_reg <= cwc_pkg::sat_add(window_reg, ca_inc);
            state      <= cwc_pkg::S_DONE;
          end
        end
        cwc_pkg::S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= cwc_pkg::S_IDLE;
          end
        end
        default: state <= cwc_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cwc_pkg::S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0000, dup_counter, fired, slow_start_flag, threshold_reg, window_reg};
    end
  end

endmodule

// ===== design/cwc_checker.sv =====
module cwc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cwc_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [cwc_pkg::WIN_W-1:0] window;
  logic [cwc_pkg::THR_W-1:0] threshold;
  logic                      ss_active;
  logic                      fast_retransmit;
  logic [cwc_pkg::DUP_W-1:0] duplicate_count;

  assign window          = m_tdata[31:0];
  assign threshold       = m_tdata[47:32];
  assign ss_active       = m_tdata[48];
  assign fast_retransmit = m_tdata[49];
  assign duplicate_count = m_tdata[51:50];

  // a pending word is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // fast retransmit restarts slow start at one segment
  a_fr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && fast_retransmit |->
      window == cwc_pkg::ONE_SEGMENT && ss_active && duplicate_count == '0
      && threshold >= 16'd2)
    else $error("bad fast retransmit result");

  // window never below one segment
  a_win: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> window >= cwc_pkg::ONE_SEGMENT)
    else $error("window below one segment");

  // one word in, at most one word out: no acceptance right after acceptance
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

endmodule

bind congestion_window_controller_top cwc_checker u_cwc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/cwnd_checker.sv =====
module cwnd_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [cwc_pkg::ACK_W-1:0]         s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [cwc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cwc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]    pwdata,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]    prdata,
  input  logic                              pready,
  output int                                mismatches,
  output int                                outstanding,
  output int                                results_checked,
  output int                                retransmits
);

  localparam logic [1:0]  DUP_TRIGGER = cwc_pkg::DUP_LIMIT_DEF;
  localparam logic [31:0] SEGMENT     = 32'h0001_0000;
  localparam logic [31:0] SSTHRESH_MIN = 32'd2;

  typedef struct packed {
    logic [31:0] window;
    logic [15:0] threshold;
    logic        ss_on;
    logic        fast_rtx;
    logic [1:0]  dup_count;
  } cwnd_word_t;

  cwnd_word_t expected_words[$];

  // shadow of the controller state
  logic [31:0] cwnd;
  logic [15:0] ssthresh;
  logic [15:0] init_ssthresh;
  logic        in_ss;
  logic [31:0] prev_ack;
  logic        have_ack;
  logic [1:0]  dups;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    retransmits     = 0;
  end

  task automatic log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic advance_window(input logic [31:0] ack, output cwnd_word_t w);
    logic [32:0] sum;
    logic [63:0] incr;
    logic [31:0] half;
    w.fast_rtx = 1'b0;
    if (have_ack && ack == prev_ack) begin
      dups = dups + 2'd1;
      if (dups == DUP_TRIGGER) begin
        half = cwnd >> 17;
        if (half < SSTHRESH_MIN) half = SSTHRESH_MIN;
        ssthresh = half[15:0];
        cwnd     = SEGMENT;
        in_ss    = 1'b1;
        dups     = 2'd0;
        w.fast_rtx = 1'b1;
      end
    end else begin
      dups     = 2'd0;
      prev_ack = ack;
      have_ack = 1'b1;
      if (in_ss) begin
        sum  = {1'b0, cwnd} + {1'b0, SEGMENT};
        cwnd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        // exit test is made on the grown window
        if (cwnd >= {ssthresh, 16'h0000}) in_ss = 1'b0;
      end else begin
        incr = (cwnd == 32'd0) ? 64'd0 : (64'h1_0000_0000 / {32'd0, cwnd});
        // increment is kept to 32 bits
        sum  = {1'b0, cwnd} + {1'b0, incr[31:0]};
        cwnd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
    w.window    = cwnd;
    w.threshold = ssthresh;
    w.ss_on     = in_ss;
    w.dup_count = dups;
  endtask

  always @(posedge clk) begin
    cwnd_word_t got;
    cwnd_word_t want;
    if (rst) begin
      init_ssthresh = cwc_pkg::THRESHOLD_RESET;
      ssthresh      = cwc_pkg::THRESHOLD_RESET;
      cwnd          = SEGMENT;
      in_ss         = 1'b1;
      prev_ack      = 32'd0;
      have_ack      = 1'b0;
      dups          = 2'd0;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.window    = m_tdata[31:0];
        got.threshold = m_tdata[47:32];
        got.ss_on     = m_tdata[48];
        got.fast_rtx  = m_tdata[49];
        got.dup_count = m_tdata[51:50];
        if (expected_words.size() == 0) begin
          log_error($sformatf("unexpected result word %h", m_tdata));
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (got !== want || m_tdata[55:52] !== 4'd0)
            log_error($sformatf({"word %0d: exp win=%h thr=%0d ss=%b frt=%b dup=%0d, ",
                                 "got win=%h thr=%0d ss=%b frt=%b dup=%0d pad=%h"},
              results_checked, want.window, want.threshold, want.ss_on,
              want.fast_rtx, want.dup_count, got.window, got.threshold,
              got.ss_on, got.fast_rtx, got.dup_count, m_tdata[55:52]));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_window(s_tdata, want);
        if (want.fast_rtx) retransmits++;
        expected_words.push_back(want);
      end
      if (psel && penable && pready && paddr == cwc_pkg::ADDR_INIT_THR) begin
        if (pwrite) begin
          // a write also reloads the live threshold
          init_ssthresh = pwdata[15:0];
          ssthresh      = pwdata[15:0];
        end else if (prdata !== {16'h0000, init_ssthresh}) begin
          log_error($sformatf("threshold readback: exp %0d, got %h", init_ssthresh, prdata));
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

// ===== sim/congestion_window_controller_top_tb.sv =====
module congestion_window_controller_top_tb;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [cwc_pkg::ACK_W-1:0]         s_tdata;   // [31:0] ack_number
  logic                              m_tvalid;
  logic                              m_tready;
  // [31:0] window, [47:32] threshold, [48] slow-start flag,
  // [49] fast_retransmit, [51:50] duplicate_count, [55:52] zero
  logic [cwc_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [cwc_pkg::CFG_ADDR_W-1:0]    paddr;
  logic [cwc_pkg::CFG_DATA_W-1:0]    pwdata;
  logic [cwc_pkg::CFG_DATA_W-1:0]    prdata;
  logic                              pready;

  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   retransmits;
  int   acks_sent;
  bit   stalls_on;
  logic [31:0] cur_ack;

  congestion_window_controller_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cwnd_checker cwnd_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .retransmits     (retransmits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("congestion_window_controller_top_tb: errors");
    $finish;
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (stalls_on) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_ack(input logic [31:0] ack);
    s_tvalid <= 1'b1;
    s_tdata  <= ack;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    acks_sent++;
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= cwc_pkg::ADDR_INIT_THR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] thr);
    drain();
    // some idle time before the register write
    repeat (40) @(negedge clk);
    apb_access(1'b1, {16'h0000, thr});
    apb_access(1'b0, 32'd0);
  endtask

  // mostly advancing acks with bursts of duplicates, some noise
  task automatic run_phase(input int n);
    int          sent;
    int          kind;
    int          reps;
    bit          paused;
    logic [31:0] older;
    sent    = 0;
    paused  = 1'b0;
    older   = $urandom;
    cur_ack = $urandom;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        if ($urandom_range(0, 9) == 0) cur_ack = cur_ack + $urandom;
        else cur_ack = cur_ack + $urandom_range(1, 1460);
        send_ack(cur_ack);
        sent++;
      end else if (kind < 85) begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          send_ack(cur_ack);
          sent++;
        end
      end else if (kind < 95) begin
        older   = cur_ack;
        cur_ack = $urandom;
        send_ack(cur_ack);
        sent++;
      end else begin
        cur_ack = older;
        send_ack(cur_ack);
        sent++;
      end
      if (!paused && sent >= n / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    acks_sent = 0;
    stalls_on = 1'b1;
    cur_ack   = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of the threshold register
    apb_access(1'b0, 32'd0);

    // first ack equals the cleared previous ack but still counts as new
    send_ack(32'h0000_0000);
    send_ack(32'h0000_0000);
    send_ack(32'h0000_0000);
    send_ack(32'h0000_0000);   // third duplicate, small window floors threshold
    send_ack(32'hFFFF_FFFF);
    send_ack(32'hFFFF_FFFF);
    send_ack(32'h8000_0000);   // new ack clears the duplicate count
    send_ack(32'h8000_0000);
    send_ack(32'h8000_0000);
    send_ack(32'h8000_0000);
    send_ack(32'h7FFF_FFFF);
    send_ack(32'h5555_5555);
    send_ack(32'hAAAA_AAAA);

    // minimum threshold: new acks in congestion avoidance, then a fast retransmit
    set_threshold(16'd2);
    send_ack(32'd1);
    send_ack(32'd2);
    send_ack(32'd3);
    send_ack(32'd3);
    send_ack(32'd3);
    send_ack(32'd3);

    // thresholds below the legal range are used as written
    set_threshold(16'd0);
    send_ack(32'd5);
    send_ack(32'd6);
    set_threshold(16'd1);
    send_ack(32'd7);
    send_ack(32'd8);

    set_threshold(16'hFFFF);
    run_phase(171);
    set_threshold(16'd2);
    run_phase(171);
    set_threshold(16'd1);
    run_phase(171);
    set_threshold(16'd64);
    run_phase(171);
    set_threshold(16'($urandom_range(3, 200)));
    run_phase(171);
    set_threshold(16'($urandom_range(2, 65535)));
    stalls_on = 1'b0;
    run_phase(171);

    drain();
    repeat (40) @(negedge clk);

    $display("%0d acks driven, %0d result words checked, %0d fast retransmits",
             acks_sent, results_checked, retransmits);
    $display("thresholds covered: 0, 1, 2, 64, 65535 and random values");
    if (mismatches == 0) begin
      $display("congestion_window_controller_top_tb: clean");
    end else begin
      $display("congestion_window_controller_top_tb: errors");
    end
    $finish;
  end

endmodule
